>>> hw/rtl/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants for the stereo linear resample mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package srm_pkg;

    // item commands
    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_MIX   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_STEP_SIZE = 1'b0,
        REG_VOLUME    = 1'b1
    } cfg_reg_t;

    localparam int STEP_W   = 18;
    localparam int VOLUME_W = 8;
    localparam int SAMPLE_W = 16;
    localparam int PHASE_W  = 16;
    localparam int OWED_W   = 3;
    localparam int CFG_W    = 18;

    localparam logic [STEP_W-1:0]   STEP_RESET   = 18'd90203;
    localparam logic [VOLUME_W-1:0] VOLUME_RESET = 8'd0;
    localparam logic [OWED_W-1:0]   OWED_PRIMED  = 3'd2;
    localparam logic [OWED_W-1:0]   OWED_MAX     = 3'd7;

    // rounding bias for the divide by 255, and ceil(2^31 / 255)
    localparam logic [22:0] ROUND_BIAS = 23'd127;
    localparam logic [23:0] RECIP_255  = 24'h808081;

    localparam logic signed [17:0] SAMPLE_MAX = 18'sd32767;
    localparam logic signed [17:0] SAMPLE_MIN = -18'sd32768;

    // per-cycle stage control shared by both lanes
    typedef struct packed {
        logic take;     // input transaction loads stage 1
        logic advance;  // stage 1 item is processed this cycle
        cmd_t cmd;      // command held in stage 1
    } srm_lane_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/srm_lane.sv
// ----------------------------------------------------------------------------
// srm_lane
// One audio channel: volume scaling, two-frame window, interpolation and
// saturating mix.
// ----------------------------------------------------------------------------
`default_nettype none

module srm_lane (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  srm_pkg::srm_lane_ctl_t       ctl,
    input  wire logic signed [15:0]      sample_in,
    input  wire logic [7:0]              volume,
    input  wire logic [15:0]             phase,
    output logic signed [15:0]           mixed_out
);
    import srm_pkg::*;

    // stage 1
    logic signed [23:0] s1_prod_reg;
    logic signed [23:0] s1_prod_next;
    logic signed [15:0] s1_base_reg;

    // window
    logic signed [15:0] older_reg;
    logic signed [15:0] newer_reg;
    logic signed [15:0] older_next;
    logic signed [15:0] newer_next;

    // stage 2
    logic signed [33:0] s2_prod_reg;
    logic signed [33:0] s2_prod_next;
    logic signed [15:0] s2_older_reg;
    logic signed [15:0] s2_base_reg;

    logic signed [23:0] samp_ext;
    logic signed [23:0] vol_ext;
    logic               prod_neg;
    logic [23:0]        prod_abs;
    logic [22:0]        biased;
    logic [46:0]        quot_wide;
    logic [15:0]        quot;
    logic signed [15:0] scaled;
    logic signed [16:0] diff;
    logic signed [16:0] lerp_step;
    logic signed [17:0] mix_sum;

    // push: s * volume, formed on the incoming sample
    assign samp_ext     = 24'(sample_in);
    assign vol_ext      = $signed({16'd0, volume});
    assign s1_prod_next = samp_ext * vol_ext;

    // (|p| + 127) / 255 by reciprocal, exact for |p| below 2^23
    assign prod_neg  = s1_prod_reg[23];
    assign prod_abs  = prod_neg ? 24'(-s1_prod_reg) : 24'(s1_prod_reg);
    assign biased    = prod_abs[22:0] + ROUND_BIAS;
    assign quot_wide = 47'(biased) * 47'(RECIP_255);
    assign quot      = quot_wide[46:31];
    assign scaled    = $signed(prod_neg ? 16'd0 - quot : quot);

    // mix: (newer - older) * phase, floor taken in the next stage
    assign diff         = 17'(newer_reg) - 17'(older_reg);
    assign s2_prod_next = 34'(diff) * $signed({18'd0, phase});

    always_comb begin
        older_next = older_reg;
        newer_next = newer_reg;
        if (ctl.advance) begin
            case (ctl.cmd)
                CMD_PUSH: begin
                    older_next = newer_reg;
                    newer_next = scaled;
                end
                CMD_CLEAR: begin
                    older_next = '0;
                    newer_next = '0;
                end
                default: begin
                    older_next = older_reg;
                    newer_next = newer_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            older_reg <= '0;
            newer_reg <= '0;
        end else begin
            older_reg <= older_next;
            newer_reg <= newer_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.take) begin
            s1_prod_reg <= s1_prod_next;
            s1_base_reg <= sample_in;
        end
        if (ctl.advance && ctl.cmd == CMD_MIX) begin
            s2_prod_reg  <= s2_prod_next;
            s2_older_reg <= older_reg;
            s2_base_reg  <= s1_base_reg;
        end
    end

    // arithmetic shift is the floor for both signs
    assign lerp_step = s2_prod_reg[32:16];
    assign mix_sum   = 18'(s2_older_reg) + 18'(lerp_step) + 18'(s2_base_reg);

    always_comb begin
        if (mix_sum > SAMPLE_MAX) begin
            mixed_out = SAMPLE_MAX[15:0];
        end else if (mix_sum < SAMPLE_MIN) begin
            mixed_out = SAMPLE_MIN[15:0];
        end else begin
            mixed_out = mix_sum[15:0];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/stereo_linear_resample_mixer.sv
// ----------------------------------------------------------------------------
// stereo_linear_resample_mixer
// Stereo linear-interpolating rate converter and mixer with volume scaling.
// ----------------------------------------------------------------------------
// channel   direction  handshake              payload
// s_        in         s_valid / s_ready      s_command, s_left_value, s_right_value
// m_        out        m_valid / m_ready      m_mixed_left, m_mixed_right,
//                                             m_frames_owed, m_underrun
// cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle sustained while s_ready is high; a mix result
// is registered behind the scale multiply, the interpolation multiply and the
// output register. window, phase and owed count update in stage 1 in order.
// reset: synchronous, restores register defaults, empties the window, two
// frames owed. s_ready drops only when a mix waits in stage 1 behind a full
// stage 2 and an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_linear_resample_mixer (
    input  wire                          aclk,
    input  wire                          aresetn,

    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire logic [1:0]              s_command,
    input  wire logic signed [15:0]      s_left_value,
    input  wire logic signed [15:0]      s_right_value,

    output logic                         m_valid,
    input  wire                          m_ready,
    output logic signed [15:0]           m_mixed_left,
    output logic signed [15:0]           m_mixed_right,
    output logic [2:0]                   m_frames_owed,
    output logic                         m_underrun,

    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [0:0]              cfg_index,
    input  wire logic [17:0]             cfg_data
);
    import srm_pkg::*;

    logic [STEP_W-1:0]   step_size_reg;
    logic [VOLUME_W-1:0] volume_reg;

    logic                r1_valid_reg;
    logic                r1_valid_next;
    cmd_t                r1_cmd_reg;

    logic [PHASE_W-1:0]  phase_reg;
    logic [PHASE_W-1:0]  phase_next;
    logic [OWED_W-1:0]   owed_reg;
    logic [OWED_W-1:0]   owed_next;

    logic                r2_valid_reg;
    logic                r2_valid_next;
    logic [OWED_W-1:0]   r2_owed_reg;
    logic                r2_under_reg;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic signed [15:0]  m_left_reg;
    logic signed [15:0]  m_right_reg;
    logic [OWED_W-1:0]   m_owed_reg;
    logic                m_under_reg;

    logic                take;
    logic                out_free;
    logic                r2_free;
    logic                adv1;
    logic                adv2;
    logic                mix_adv;
    logic [18:0]         phase_acc;
    logic [3:0]          owed_sum;
    logic signed [15:0]  lane_left;
    logic signed [15:0]  lane_right;
    srm_lane_ctl_t       lane_ctl;

    // configuration
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_size_reg <= STEP_RESET;
            volume_reg    <= VOLUME_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_STEP_SIZE: step_size_reg <= cfg_data[STEP_W-1:0];
                REG_VOLUME:    volume_reg    <= cfg_data[VOLUME_W-1:0];
                default:       step_size_reg <= step_size_reg;
            endcase
        end
    end

    // pipeline flow
    assign out_free = !m_valid_reg || m_ready;
    assign adv2     = r2_valid_reg && out_free;
    assign r2_free  = !r2_valid_reg || out_free;
    assign adv1     = r1_valid_reg && (r1_cmd_reg != CMD_MIX || r2_free);
    assign mix_adv  = adv1 && r1_cmd_reg == CMD_MIX;
    assign s_ready  = !r1_valid_reg || adv1;
    assign take     = s_valid && s_ready;

    assign r1_valid_next = take ? 1'b1 : (adv1 ? 1'b0 : r1_valid_reg);
    assign r2_valid_next = mix_adv ? 1'b1 : (adv2 ? 1'b0 : r2_valid_reg);
    assign m_valid_next  = adv2 ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    // phase and owed count
    assign phase_acc = 19'(phase_reg) + 19'(step_size_reg);
    assign owed_sum  = 4'(owed_reg) + 4'(phase_acc[18:16]);

    always_comb begin
        phase_next = phase_reg;
        owed_next  = owed_reg;
        if (adv1) begin
            case (r1_cmd_reg)
                CMD_PUSH: begin
                    if (owed_reg != '0) begin
                        owed_next = owed_reg - 3'd1;
                    end
                end
                CMD_MIX: begin
                    phase_next = phase_acc[PHASE_W-1:0];
                    owed_next  = (owed_sum > 4'(OWED_MAX)) ? OWED_MAX : owed_sum[OWED_W-1:0];
                end
                CMD_CLEAR: begin
                    phase_next = '0;
                    owed_next  = OWED_PRIMED;
                end
                default: begin
                    phase_next = phase_reg;
                    owed_next  = owed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r1_valid_reg <= 1'b0;
            r2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= '0;
            owed_reg     <= OWED_PRIMED;
        end else begin
            r1_valid_reg <= r1_valid_next;
            r2_valid_reg <= r2_valid_next;
            m_valid_reg  <= m_valid_next;
            phase_reg    <= phase_next;
            owed_reg     <= owed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            r1_cmd_reg <= cmd_t'(s_command);
        end
        if (mix_adv) begin
            r2_owed_reg  <= owed_next;
            r2_under_reg <= (owed_reg != '0);
        end
        if (adv2) begin
            m_left_reg  <= lane_left;
            m_right_reg <= lane_right;
            m_owed_reg  <= r2_owed_reg;
            m_under_reg <= r2_under_reg;
        end
    end

    assign lane_ctl.take    = take;
    assign lane_ctl.advance = adv1;
    assign lane_ctl.cmd     = r1_cmd_reg;

    srm_lane u_lane_left (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (lane_ctl),
        .sample_in (s_left_value),
        .volume    (volume_reg),
        .phase     (phase_reg),
        .mixed_out (lane_left)
    );

    srm_lane u_lane_right (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (lane_ctl),
        .sample_in (s_right_value),
        .volume    (volume_reg),
        .phase     (phase_reg),
        .mixed_out (lane_right)
    );

    assign m_valid       = m_valid_reg;
    assign m_mixed_left  = m_left_reg;
    assign m_mixed_right = m_right_reg;
    assign m_frames_owed = m_owed_reg;
    assign m_underrun    = m_under_reg;

`ifndef ASSERT_OFF
    // a result only appears when stage 2 held a mix
    a_out_from_stage2: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(r2_valid_reg))
        else $error("result without a mix in stage 2");

    // only a blocked mix can hold the input off
    a_stall_only_mix: assert property (@(posedge aclk) disable iff (!aresetn)
        (r1_valid_reg && !s_ready) |-> (r1_cmd_reg == CMD_MIX && !r2_free))
        else $error("input stalled without a blocked mix");

    // clear primes the window
    a_clear_primes: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && r1_cmd_reg == CMD_CLEAR) |=> (owed_reg == OWED_PRIMED && phase_reg == '0))
        else $error("clear did not prime the window");

    // a push pays one owed frame
    a_push_pays: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv1 && r1_cmd_reg == CMD_PUSH && owed_reg != '0)
            |=> (owed_reg == $past(owed_reg) - 3'd1))
        else $error("push did not pay an owed frame");

    // stage 2 holds its mix while the result waits
    a_stage2_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (r2_valid_reg && m_valid_reg && !m_ready) |=> r2_valid_reg)
        else $error("stage 2 mix lost under stall");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the stereo linear resample mixer. A shadow of the
// volume scaler, two-frame window, phase accumulator and owed-frame counter
// predicts every mix result; a monitor compares each returned result field by
// field. Directed cases cover reset defaults, full-scale saturation, gain
// rounding and step extremes. Random traffic then runs primed push/mix
// sequences mixed with clears, stray pushes, underruns and the unused
// command, under several step and volume settings and random handshake gaps.
// ----------------------------------------------------------------------------

module tb_top;
    import srm_pkg::*;

    // the block has no command at this code and must ignore it
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // wait for a mix result to leave the output register, with margin on top
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES = 300;
    // longest quiet spell is the receiver hold-off; take it many times over
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_PER_PHASE = 135;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [2:0]         owed;
        logic               underrun;
    } mixed_out_t;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    logic [1:0]          s_command;
    logic signed [15:0]  s_left_value;
    logic signed [15:0]  s_right_value;
    logic                m_valid;
    logic                m_ready;
    logic signed [15:0]  m_mixed_left;
    logic signed [15:0]  m_mixed_right;
    logic [2:0]          m_frames_owed;
    logic                m_underrun;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [0:0]          cfg_index;
    logic [17:0]         cfg_data;

    stereo_linear_resample_mixer uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_left_value  (s_left_value),
        .s_right_value (s_right_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_mixed_left  (m_mixed_left),
        .m_mixed_right (m_mixed_right),
        .m_frames_owed (m_frames_owed),
        .m_underrun    (m_underrun),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow state of the mixer
    logic [STEP_W-1:0]   step_now;
    logic [VOLUME_W-1:0] gain_now;
    logic [15:0]         read_phase;
    logic signed [15:0]  win_old_l, win_old_r, win_new_l, win_new_r;
    logic [2:0]          frames_due;

    mixed_out_t expected_mixes[$];

    int fail_count      = 0;
    int items_taken     = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int tx_idle_pct     = 33;
    int rx_idle_pct     = 33;
    logic hold_request  = 1'b0;

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    function automatic logic signed [15:0] apply_gain(input logic signed [15:0] s);
        int prod;
        int mag;
        int q;
        prod = int'(s) * int'(gain_now);
        mag = (prod < 0) ? -prod : prod;
        q = (mag + 127) / 255;
        return 16'((prod < 0) ? -q : q);
    endfunction

    // floor of the weighted difference, so negative slopes round down
    function automatic int blend(input logic signed [15:0] a, input logic signed [15:0] b,
                                 input logic [15:0] t);
        longint prod;
        prod = longint'(int'(b) - int'(a)) * longint'(t);
        return int'(a) + int'(prod >>> 16);
    endfunction

    function automatic logic signed [15:0] clip16(input int v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic void empty_window();
        read_phase = '0;
        win_old_l  = '0;
        win_old_r  = '0;
        win_new_l  = '0;
        win_new_r  = '0;
        frames_due = OWED_PRIMED;
    endfunction

    function automatic void update_resampler(input logic [1:0] cmd,
                                             input logic signed [15:0] lv,
                                             input logic signed [15:0] rv);
        mixed_out_t res;
        int acc;
        int owed_sum;
        case (cmd)
            CMD_PUSH: begin
                win_old_l = win_new_l;
                win_old_r = win_new_r;
                win_new_l = apply_gain(lv);
                win_new_r = apply_gain(rv);
                if (frames_due != 0) frames_due = frames_due - 1'b1;
            end
            CMD_CLEAR: empty_window();
            CMD_MIX: begin
                res.underrun = (frames_due != 0);
                res.left  = clip16(int'(lv) + blend(win_old_l, win_new_l, read_phase));
                res.right = clip16(int'(rv) + blend(win_old_r, win_new_r, read_phase));
                acc = int'(read_phase) + int'(step_now);
                read_phase = acc[15:0];
                owed_sum = int'(frames_due) + (acc >>> 16);
                frames_due = (owed_sum > int'(OWED_MAX)) ? OWED_MAX : owed_sum[2:0];
                res.owed = frames_due;
                expected_mixes.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void compare_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_mix_result();
        mixed_out_t want;
        if (expected_mixes.size() == 0) begin
            $error("mix result with none expected: left %0d right %0d",
                   m_mixed_left, m_mixed_right);
            fail_count++;
        end else begin
            want = expected_mixes.pop_front();
            compare_field("mixed_left", int'(want.left), int'(m_mixed_left));
            compare_field("mixed_right", int'(want.right), int'(m_mixed_right));
            compare_field("frames_owed", int'(want.owed), int'(m_frames_owed));
            compare_field("underrun", int'(want.underrun), int'(m_underrun));
            results_checked++;
        end
    endfunction

    // monitor: every transaction on the three channels, sampled at the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            step_now = STEP_RESET;
            gain_now = VOLUME_RESET;
            empty_window();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_index))
                    REG_STEP_SIZE: step_now = cfg_data;
                    REG_VOLUME:    gain_now = cfg_data[VOLUME_W-1:0];
                    default: ;
                endcase
                reg_writes++;
            end
            if (m_valid && m_ready) check_mix_result();
            if (s_valid && s_ready) begin
                update_resampler(s_command, s_left_value, s_right_value);
                if (s_command != CMD_UNUSED) items_taken++;
            end
        end
    end

    // watchdog: ends a run that stops moving
    int quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random back-pressure, plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            m_ready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // drivers; every task starts and ends at a falling edge
    // ------------------------------------------------------------------
    task automatic send_item(input logic [1:0] cmd, input logic signed [15:0] lv,
                             input logic signed [15:0] rv);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid       = 1'b1;
        s_command     = cmd;
        s_left_value  = lv;
        s_right_value = rv;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid = 1'b0;
        while (expected_mixes.size() != 0) @(negedge aclk);
    endtask

    // pushes and clears give no result, so allow them to leave the pipe too
    task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_rate_and_gain(input logic [STEP_W-1:0] step,
                                     input logic [VOLUME_W-1:0] vol);
        write_register(REG_STEP_SIZE, step);
        write_register(REG_VOLUME, CFG_W'(vol));
    endtask

    function automatic logic signed [15:0] random_sample();
        case ($urandom_range(15))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'sh0000;
            3: return 16'shffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        // zero gain and the default step; first mix is an underrun
        send_item(CMD_MIX, 16'sd1234, -16'sd1234);
        send_item(CMD_PUSH, 16'sh7fff, 16'sh8000);
        send_item(CMD_PUSH, -16'sd1, 16'sd1);
        send_item(CMD_MIX, 16'sh7fff, 16'sh8000);
    endtask

    task automatic test_full_scale_window();
        set_rate_and_gain(18'd32768, 8'd255);
        send_item(CMD_CLEAR, 16'sd0, 16'sd0);
        send_item(CMD_PUSH, 16'sh7fff, 16'sh8000);
        send_item(CMD_PUSH, 16'sh8000, 16'sh7fff);
        // both directions of saturation, at phase zero and at one half
        send_item(CMD_MIX, 16'sh7fff, 16'sh8000);
        send_item(CMD_MIX, 16'sh8000, 16'sh7fff);
        send_item(CMD_PUSH, 16'sd12345, -16'sd12345);
        // nothing owed here, frame still shifts in
        send_item(CMD_PUSH, -16'sd1, 16'sd1);
        send_item(CMD_UNUSED, 16'sh5555, 16'shaaaa);
        send_item(CMD_CLEAR, 16'shffff, 16'shffff);
        send_item(CMD_MIX, 16'sd100, -16'sd100);
    endtask

    task automatic test_gain_rounding();
        set_rate_and_gain(18'd65536, 8'd1);
        send_item(CMD_CLEAR, 16'sd0, 16'sd0);
        send_item(CMD_PUSH, 16'sd127, -16'sd127);
        send_item(CMD_PUSH, 16'sd128, -16'sd128);
        send_item(CMD_PUSH, 16'sh8000, 16'sh7fff);
        send_item(CMD_MIX, 16'sd0, 16'sd0);
    endtask

    task automatic test_step_extremes();
        write_register(REG_STEP_SIZE, 18'd0);
        send_item(CMD_CLEAR, 16'sd0, 16'sd0);
        send_item(CMD_MIX, 16'sd1, 16'sd2);
        write_register(REG_STEP_SIZE, 18'h3ffff);
        // owed count climbs past its ceiling
        send_item(CMD_MIX, 16'sd3, 16'sd4);
        send_item(CMD_MIX, 16'sd5, 16'sd6);
        write_register(REG_STEP_SIZE, 18'd1);
        send_item(CMD_MIX, 16'sd7, 16'sd8);
    endtask

    task automatic test_output_backpressure();
        int n;
        tx_idle_pct = 0;
        hold_request = 1'b1;
        for (n = 0; n < 32; n++) send_item(CMD_MIX, random_sample(), random_sample());
        for (n = 0; n < 16; n++) send_item(CMD_PUSH, random_sample(), random_sample());
        tx_idle_pct = 33;
        // sender waits for the backlog before going on
        wait_results_drained();
        @(negedge aclk);
    endtask

    task automatic run_random_traffic(input int count);
        int sent;
        int pick;
        int due;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 78) begin
                // primed sequence: pay every owed frame, then mix
                due = int'(frames_due);
                repeat (due) begin
                    send_item(CMD_PUSH, random_sample(), random_sample());
                    sent++;
                end
                send_item(CMD_MIX, random_sample(), random_sample());
                sent++;
            end else if (pick < 87) begin
                send_item(CMD_MIX, random_sample(), random_sample());
                sent++;
            end else if (pick < 93) begin
                send_item(CMD_PUSH, random_sample(), random_sample());
                sent++;
            end else if (pick < 96) begin
                send_item(CMD_CLEAR, random_sample(), random_sample());
                sent++;
            end else if (pick < 99) begin
                send_item(CMD_UNUSED, random_sample(), random_sample());
            end else begin
                wait_results_drained();
                @(negedge aclk);
            end
        end
    endtask

    task automatic test_random_traffic();
        set_rate_and_gain(18'd90203, 8'd255);
        run_random_traffic(RANDOM_PER_PHASE);
        set_rate_and_gain(18'd1, 8'd128);
        run_random_traffic(RANDOM_PER_PHASE);
        set_rate_and_gain(18'h3ffff, 8'd77);
        run_random_traffic(RANDOM_PER_PHASE);
        // stretch with no gaps on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_rate_and_gain(18'd65536, 8'd255);
        run_random_traffic(RANDOM_PER_PHASE);
        tx_idle_pct = 33;
        rx_idle_pct = 33;
        set_rate_and_gain(18'($urandom_range(262143, 1)), 8'($urandom_range(255)));
        run_random_traffic(RANDOM_PER_PHASE);
        set_rate_and_gain(18'($urandom_range(131071, 1)), 8'($urandom_range(255)));
        run_random_traffic(RANDOM_PER_PHASE);
        set_rate_and_gain(18'd32768, 8'd1);
        run_random_traffic(RANDOM_PER_PHASE);
        set_rate_and_gain(18'd0, 8'd0);
        run_random_traffic(RANDOM_PER_PHASE);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_command     = CMD_PUSH;
        s_left_value  = '0;
        s_right_value = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_STEP_SIZE;
        cfg_data      = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_reset_defaults();
        test_full_scale_window();
        test_gain_rounding();
        test_step_extremes();
        test_output_backpressure();
        test_random_traffic();

        wait_results_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_mixes.size() != 0) begin
            $error("%0d mix results never arrived", expected_mixes.size());
            fail_count++;
        end
        $display("covered %0d push/mix/clear transactions and %0d register writes",
                 items_taken, reg_writes);
        $display("checked %0d mix results over directed, back-pressure and random phases",
                 results_checked);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
